/* rtl/lzw_byte_encoder_defines.svh */
// Assertion macros used by the LZW engine RTL.
// Depends on nothing; users must have aclk and aresetn in scope.
`ifndef LZW_BYTE_ENCODER_DEFINES_SVH
`define LZW_BYTE_ENCODER_DEFINES_SVH

// Property that must hold on every clock edge out of reset
`define LZW_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// Same-cycle implication
`define LZW_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define LZW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/lzw_pkg.sv */
// Package for the LZW byte encoder: item types, queue status, engine states.
// No dependencies.
`timescale 1ns / 1ps

package lzw_pkg;

    localparam int BYTE_W = 8;
    localparam int CODE_W = 12;

    // Queue depths (powers of two)
    localparam int IN_Q_DEPTH  = 2;
    localparam int OUT_Q_DEPTH = 4;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              final_byte;
    } in_item_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              end_of_stream;
    } out_item_t;

    // Status a queue reports to its neighbors
    typedef struct packed {
        logic full;
        logic empty;
        logic almost_full;
    } q_stat_t;

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_INDEX,
        ENG_MATCH,
        ENG_FLUSH
    } eng_state_t;

endpackage

/* rtl/lzw_byte_encoder.sv */
// LZW byte encoder, 12-bit output codes. A byte passes the input queue, index probe,
// dictionary verify and decide; a final byte adds a flush. No new byte is taken until the
// last one is done, as set by the two dependent registered memory reads of the match step,
// nor while the output queue is almost full. Reset (synchronous, active low) empties the
// queues and restarts the stream; the index memory is verified against the dictionary on
// every probe, so no clearing pass is run and items are taken right after reset.
`timescale 1ns / 1ps

module lzw_byte_encoder #(
    parameter int CODE_BITS = 12
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  lzw_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output lzw_pkg::out_item_t m_data
);

    lzw_pkg::q_stat_t   in_stat, out_stat;
    lzw_pkg::in_item_t  q_item;
    lzw_pkg::out_item_t eng_item;
    logic               in_pop, out_push;

    // front: accept bytes into a short queue
    lzw_fifo #(
        .WIDTH($bits(lzw_pkg::in_item_t)),
        .DEPTH(lzw_pkg::IN_Q_DEPTH)
    ) u_in_q (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (s_valid && s_ready),
        .wr_data (s_data),
        .rd_en   (in_pop),
        .rd_data (q_item),
        .stat    (in_stat)
    );

    assign s_ready = !in_stat.full;

    // back: dictionary search and code emission
    lzw_engine #(
        .CODE_BITS(CODE_BITS)
    ) u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_item  (q_item),
        .in_stat  (in_stat),
        .in_pop   (in_pop),
        .out_item (eng_item),
        .out_stat (out_stat),
        .out_push (out_push)
    );

    // result queue decouples the engine from downstream stalls
    lzw_fifo #(
        .WIDTH($bits(lzw_pkg::out_item_t)),
        .DEPTH(lzw_pkg::OUT_Q_DEPTH)
    ) u_out_q (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (out_push),
        .wr_data (eng_item),
        .rd_en   (m_valid && m_ready),
        .rd_data (m_data),
        .stat    (out_stat)
    );

    assign m_valid = !out_stat.empty;

endmodule

/* rtl/lzw_fifo.sv */
// Small register queue used between the encoder's front, engine and output.
// Depends on lzw_pkg (q_stat_t).
`timescale 1ns / 1ps

module lzw_fifo #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output lzw_pkg::q_stat_t stat
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg + AW'(wr_en);
        rd_ptr_next = rd_ptr_reg + AW'(rd_en);
        count_next  = count_reg + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset needed
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data          = slot_reg[rd_ptr_reg];
    assign stat.full        = (count_reg == (AW+1)'(DEPTH));
    assign stat.empty       = (count_reg == '0);
    assign stat.almost_full = (count_reg >= (AW+1)'(DEPTH - 1));

endmodule

/* rtl/lzw_engine.sv */
// LZW back end: dictionary memories, match sequencer and code emission.
// Depends on lzw_pkg and lzw_byte_encoder_defines.svh.
`timescale 1ns / 1ps
`include "lzw_byte_encoder_defines.svh"

module lzw_engine #(
    parameter int CODE_BITS = 12
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  lzw_pkg::in_item_t in_item,
    input  lzw_pkg::q_stat_t  in_stat,
    output logic              in_pop,
    output lzw_pkg::out_item_t out_item,
    input  lzw_pkg::q_stat_t  out_stat,
    output logic              out_push
);

    localparam int CB         = CODE_BITS;
    localparam int KEY_W      = CB + lzw_pkg::BYTE_W;
    localparam int IDX_DEPTH  = 1 << KEY_W;
    localparam int DICT_DEPTH = (1 << CB) - 256;
    localparam int DA         = $clog2(DICT_DEPTH);
    localparam logic [CB:0] LIMIT     = {1'b1, {CB{1'b0}}};
    localparam logic [CB:0] FIRST_NEW = (CB+1)'(256);

    // Index memory: key -> code last assigned to it (never cleared, verified)
    logic [CB-1:0]    idx_mem [IDX_DEPTH];
    logic [CB-1:0]    idx_q;
    logic             idx_rd_en, idx_wr_en;
    logic [KEY_W-1:0] idx_rd_addr, idx_wr_addr;
    logic [CB-1:0]    idx_wr_data;

    // Dictionary memory: code-256 -> key
    logic [KEY_W-1:0] dict_mem [DICT_DEPTH];
    logic [KEY_W-1:0] dict_q;
    logic             dict_rd_en, dict_wr_en;
    logic [DA-1:0]    dict_rd_addr, dict_wr_addr;
    logic [KEY_W-1:0] dict_wr_data;

    lzw_pkg::eng_state_t state_reg, state_next;
    logic [CB-1:0]               prefix_reg, prefix_next;
    logic                        prefix_valid_reg, prefix_valid_next;
    logic [CB:0]                 next_free_reg, next_free_next;
    logic [lzw_pkg::BYTE_W-1:0]  byte_reg, byte_next;
    logic                        final_reg, final_next;
    logic [CB-1:0]               cand_reg, cand_next;
    logic                        cand_ok_reg, cand_ok_next;
    logic [KEY_W-1:0]            key;

    assign key = {prefix_reg, byte_reg};

    // memories, registered read data
    always_ff @(posedge aclk) begin
        if (idx_wr_en) begin
            idx_mem[idx_wr_addr] <= idx_wr_data;
        end
        if (idx_rd_en) begin
            idx_q <= idx_mem[idx_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (dict_wr_en) begin
            dict_mem[dict_wr_addr] <= dict_wr_data;
        end
        if (dict_rd_en) begin
            dict_q <= dict_mem[dict_rd_addr];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lzw_pkg::ENG_IDLE: begin
                if (!in_stat.empty && !out_stat.almost_full) begin
                    state_next = lzw_pkg::ENG_INDEX;
                end
            end
            lzw_pkg::ENG_INDEX: state_next = lzw_pkg::ENG_MATCH;
            lzw_pkg::ENG_MATCH: begin
                state_next = final_reg ? lzw_pkg::ENG_FLUSH : lzw_pkg::ENG_IDLE;
            end
            lzw_pkg::ENG_FLUSH: state_next = lzw_pkg::ENG_IDLE;
            default:            state_next = lzw_pkg::ENG_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        in_pop            = 1'b0;
        out_push          = 1'b0;
        out_item.code     = lzw_pkg::CODE_W'(prefix_reg);
        out_item.end_of_stream = 1'b0;
        idx_rd_en         = 1'b0;
        idx_rd_addr       = {prefix_reg, in_item.data_byte};
        idx_wr_en         = 1'b0;
        idx_wr_addr       = key;
        idx_wr_data       = next_free_reg[CB-1:0];
        dict_rd_en        = 1'b0;
        dict_rd_addr      = DA'(idx_q - CB'(256));
        dict_wr_en        = 1'b0;
        dict_wr_addr      = DA'(next_free_reg - FIRST_NEW);
        dict_wr_data      = key;
        prefix_next       = prefix_reg;
        prefix_valid_next = prefix_valid_reg;
        next_free_next    = next_free_reg;
        byte_next         = byte_reg;
        final_next        = final_reg;
        cand_next         = cand_reg;
        cand_ok_next      = cand_ok_reg;
        unique case (state_reg)
            lzw_pkg::ENG_IDLE: begin
                // take an item only with room for two codes downstream
                if (!in_stat.empty && !out_stat.almost_full) begin
                    in_pop     = 1'b1;
                    idx_rd_en  = 1'b1;
                    byte_next  = in_item.data_byte;
                    final_next = in_item.final_byte;
                end
            end
            lzw_pkg::ENG_INDEX: begin
                // candidate code must lie in the live range of this stream
                dict_rd_en   = 1'b1;
                cand_next    = idx_q;
                cand_ok_next = (idx_q >= CB'(256)) && ({1'b0, idx_q} < next_free_reg);
            end
            lzw_pkg::ENG_MATCH: begin
                if (!prefix_valid_reg) begin
                    prefix_next       = CB'(byte_reg);
                    prefix_valid_next = 1'b1;
                end else if (cand_ok_reg && (dict_q == key)) begin
                    prefix_next = cand_reg;
                end else begin
                    // miss: emit prefix, learn the extended string if room is left
                    out_push    = 1'b1;
                    prefix_next = CB'(byte_reg);
                    if (next_free_reg < LIMIT) begin
                        idx_wr_en      = 1'b1;
                        dict_wr_en     = 1'b1;
                        next_free_next = next_free_reg + (CB+1)'(1);
                    end
                end
            end
            lzw_pkg::ENG_FLUSH: begin
                // end of stream: flush prefix and start a fresh dictionary
                out_push               = 1'b1;
                out_item.end_of_stream = 1'b1;
                prefix_next            = '0;
                prefix_valid_next      = 1'b0;
                next_free_next         = FIRST_NEW;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= lzw_pkg::ENG_IDLE;
            prefix_reg       <= '0;
            prefix_valid_reg <= 1'b0;
            next_free_reg    <= FIRST_NEW;
        end else begin
            state_reg        <= state_next;
            prefix_reg       <= prefix_next;
            prefix_valid_reg <= prefix_valid_next;
            next_free_reg    <= next_free_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg    <= byte_next;
        final_reg   <= final_next;
        cand_reg    <= cand_next;
        cand_ok_reg <= cand_ok_next;
    end

    // checks
    `LZW_ASSERT_ALWAYS(a_free_range, (next_free_reg >= FIRST_NEW) && (next_free_reg <= LIMIT), "next free code out of range")
    `LZW_ASSERT_IMPL(a_push_state, out_push, (state_reg == lzw_pkg::ENG_MATCH) || (state_reg == lzw_pkg::ENG_FLUSH), "code pushed outside emit states")
    `LZW_ASSERT_IMPL(a_pop_room, in_pop, !out_stat.almost_full && !in_stat.empty, "item taken without output room")
    `LZW_ASSERT_NEXT(a_probe_seq, state_reg == lzw_pkg::ENG_INDEX, state_reg == lzw_pkg::ENG_MATCH, "index probe not followed by match")
    `LZW_ASSERT_IMPL(a_learn_miss, dict_wr_en, out_push && idx_wr_en, "entry learned without emit")

endmodule

/* bench/lzw_byte_encoder_tb.sv */
// Self-checking bench for lzw_byte_encoder: drives byte streams, predicts the LZW codes.
// Depends on lzw_pkg (item types and widths) and the lzw_byte_encoder RTL.
`timescale 1ns / 1ps

module lzw_byte_encoder_tb;

    localparam int FIRST_FREE   = 256;
    localparam int CODE_SPACE   = 1 << lzw_pkg::CODE_W;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_CYCLES  = 300;

    // Predicts the code stream and holds the codes still owed by the block
    class code_scoreboard;
        logic [lzw_pkg::CODE_W-1:0] prefix;
        bit                         prefix_held;
        logic [lzw_pkg::CODE_W:0]   free_code;
        logic [lzw_pkg::CODE_W-1:0] learned [logic [lzw_pkg::CODE_W+lzw_pkg::BYTE_W-1:0]];
        lzw_pkg::out_item_t         owed_codes [$];
        int                         errors;
        int                         codes_seen;

        function new();
            prefix      = '0;
            prefix_held = 1'b0;
            free_code   = (lzw_pkg::CODE_W+1)'(FIRST_FREE);
            errors      = 0;
            codes_seen  = 0;
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        // Advance the model by one accepted byte
        function void note_byte(lzw_pkg::in_item_t item);
            logic [lzw_pkg::CODE_W+lzw_pkg::BYTE_W-1:0] pair;
            logic [lzw_pkg::CODE_W-1:0]                 byte_code;
            pair      = {prefix, item.data_byte};
            byte_code = {{(lzw_pkg::CODE_W-lzw_pkg::BYTE_W){1'b0}}, item.data_byte};
            if (!prefix_held) begin
                // start of a stream: the byte itself is the prefix
                prefix      = byte_code;
                prefix_held = 1'b1;
            end else if (learned.exists(pair)) begin
                prefix = learned[pair];
            end else begin
                owed_codes = {owed_codes, lzw_pkg::out_item_t'({prefix, 1'b0})};
                // learn only while codes are left
                if (free_code < CODE_SPACE) begin
                    learned[pair] = free_code[lzw_pkg::CODE_W-1:0];
                    free_code++;
                end
                prefix = byte_code;
            end
            if (item.final_byte) begin
                owed_codes  = {owed_codes, lzw_pkg::out_item_t'({prefix, 1'b1})};
                prefix      = '0;
                prefix_held = 1'b0;
                free_code   = (lzw_pkg::CODE_W+1)'(FIRST_FREE);
                learned.delete();
            end
        endfunction

        task check_code(lzw_pkg::out_item_t got);
            lzw_pkg::out_item_t want;
            codes_seen++;
            if (owed_codes.size() == 0) begin
                report($sformatf("code #%0d: unexpected code %0d eos %0b",
                                 codes_seen, got.code, got.end_of_stream));
                return;
            end
            want = owed_codes.pop_front();
            if (got.code !== want.code)
                report($sformatf("code #%0d: code %0d, want %0d",
                                 codes_seen, got.code, want.code));
            if (got.end_of_stream !== want.end_of_stream)
                report($sformatf("code #%0d: eos %0b, want %0b",
                                 codes_seen, got.end_of_stream, want.end_of_stream));
        endtask
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    lzw_pkg::in_item_t  s_data;
    logic               m_valid;
    logic               m_ready;
    lzw_pkg::out_item_t m_data;

    code_scoreboard sb;
    int gap_pct;
    int stall_pct;
    int hold_asked;
    int hold_taken;
    int hold_left;
    int cycles;
    logic [lzw_pkg::BYTE_W:0] directed_items [$];

    lzw_byte_encoder dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Watchdog
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    // Both channels observed on the same edge; codes come out before later bytes count
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_code(m_data);
            if (s_valid && s_ready) sb.note_byte(s_data);
        end
    end

    // Receiver: random stalls, plus a long hold-off when one is asked for
    initial begin
        m_ready    = 1'b0;
        hold_taken = 0;
        hold_left  = 0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (hold_asked != hold_taken) begin
                hold_taken++;
                hold_left = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // One byte item; valid stays up from one item to the next when no gap falls
    task automatic send_byte(logic [lzw_pkg::BYTE_W-1:0] value, bit last);
        while ($urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{data_byte: value, final_byte: last};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Stream closed by a final byte; a narrow alphabet builds long matches
    task automatic send_stream(int len, bit narrow);
        logic [lzw_pkg::BYTE_W-1:0] base;
        logic [lzw_pkg::BYTE_W-1:0] value;
        int span;
        base = lzw_pkg::BYTE_W'($urandom);
        span = $urandom_range(1, 3);
        for (int i = 0; i < len; i++) begin
            value = narrow ? base + lzw_pkg::BYTE_W'($urandom_range(0, span))
                           : lzw_pkg::BYTE_W'($urandom);
            send_byte(value, i == len - 1);
        end
    endtask

    task automatic run_phase(int gap, int stall, int items);
        int sent;
        int len;
        gap_pct   = gap;
        stall_pct = stall;
        sent      = 0;
        while (sent < items) begin
            case ($urandom_range(0, 9))
                0: begin
                    len = 1;
                end
                1, 2: begin
                    len = $urandom_range(31, 120);
                end
                default: begin
                    len = $urandom_range(2, 30);
                end
            endcase
            send_stream(len, 1'($urandom_range(0, 1)));
            sent += len;
        end
    endtask

    initial begin
        sb         = new();
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        gap_pct    = 0;
        stall_pct  = 0;
        hold_asked = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: lone final bytes at both extremes, a repeating pair that
        // grows the prefix, the same pair in a fresh stream, a final byte that
        // misses (two codes) and a final byte that hits (one code)
        directed_items = '{
            {8'h00, 1'b1}, {8'hFF, 1'b1},
            {8'h41, 1'b0}, {8'h42, 1'b0}, {8'h41, 1'b0}, {8'h42, 1'b0},
            {8'h41, 1'b0}, {8'h42, 1'b0}, {8'h41, 1'b0}, {8'h42, 1'b1},
            {8'h41, 1'b0}, {8'h42, 1'b1},
            {8'h55, 1'b0}, {8'hAA, 1'b0}, {8'h00, 1'b1},
            {8'hFF, 1'b0}, {8'hFF, 1'b0}, {8'hFF, 1'b1},
            {8'h80, 1'b0}, {8'h01, 1'b0}, {8'h7F, 1'b1}
        };
        foreach (directed_items[i])
            send_byte(directed_items[i][lzw_pkg::BYTE_W:1], directed_items[i][0]);

        // Random streams under the idling mixes
        run_phase(0, 0, 150);
        run_phase(47, 0, 150);
        run_phase(0, 47, 150);
        run_phase(32, 32, 150);

        // Receiver held off while bytes keep coming, so the input backs up
        hold_asked++;
        run_phase(0, 0, 45);

        s_valid  <= 1'b0;
        stall_pct = 0;
        while (sb.owed_codes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.owed_codes.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* lzw_byte_encoder.f */
+incdir+rtl
rtl/lzw_pkg.sv
rtl/lzw_fifo.sv
rtl/lzw_engine.sv
rtl/lzw_byte_encoder.sv
bench/lzw_byte_encoder_tb.sv
